// ----- rtl/core/wdu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wdu_pkg
// Shared types and constants of the weighted depth upsampler.
// ----------------------------------------------------------------------------
package wdu_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_RANGE_X = 2'd0;
  localparam logic [1:0] CFG_RANGE_Y = 2'd1;
  localparam logic [1:0] CFG_RANGE_Z = 2'd2;

  localparam logic [30:0] RANGE_RESET = 31'd65536;

  // Saturation limits
  localparam logic [31:0] WEIGHT_MAX = 32'hFFFF_FFFF;
  localparam logic [30:0] EST_MAX    = 31'h7FFF_FFFF;
  localparam logic [7:0]  BYTE_MAX   = 8'hFF;
  localparam logic [8:0]  BYTE_SCALE = 9'd255;

  // Square root takes a 64-bit radicand, two bits per step
  localparam int SQRT_IN_W  = 64;
  localparam int SQRT_STEPS = 32;

  // Operation of the shared compare-subtract unit
  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/wdu_serial_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wdu_serial_unit
// Shared compare-subtract unit: restoring division one quotient bit per
// cycle, or integer square root two radicand bits per cycle.
// ----------------------------------------------------------------------------
module wdu_serial_unit #(
  parameter int UN = 79,
  parameter int UD = 70
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wdu_pkg::unit_ctl_t    ctl,
  input  wire        [UN-1:0]   num,
  input  wire        [UD-1:0]   den,
  output wdu_pkg::unit_sts_t    sts,
  output logic       [UN-1:0]   quo,
  output logic       [31:0]     root
);

  localparam int CW = $clog2(UN + 1);

  logic               busy_r, busy_nxt;
  wdu_pkg::unit_op_t  op_r, op_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [UD:0]        rem_r, rem_nxt;
  logic [UN-1:0]      sh_r, sh_nxt;
  logic [31:0]        root_r, root_nxt;
  logic [UD-1:0]      den_r, den_nxt;

  logic [UD:0]        rem_sh, trial, diff;
  logic               ge, last;

  // One compare-subtract step
  always_comb begin
    if (op_r == wdu_pkg::OP_DIV) begin
      rem_sh = {rem_r[UD-1:0], sh_r[UN-1]};
      trial  = {1'b0, den_r};
    end else begin
      rem_sh = {rem_r[UD-2:0], sh_r[UN-1:UN-2]};
      trial  = (UD+1)'({root_r, 2'b01});
    end
    ge   = rem_sh >= trial;
    diff = rem_sh - trial;
    last = cnt_r == CW'(1);
  end

  // Sequencing
  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    root_nxt = root_r;
    den_nxt  = den_r;
    if (busy_r) begin
      rem_nxt = ge ? diff : rem_sh;
      cnt_nxt = cnt_r - CW'(1);
      if (op_r == wdu_pkg::OP_DIV) begin
        sh_nxt = {sh_r[UN-2:0], ge};
      end else begin
        sh_nxt   = {sh_r[UN-3:0], 2'b00};
        root_nxt = {root_r[30:0], ge};
      end
      if (last) begin
        busy_nxt = 1'b0;
      end
    end else if (ctl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctl.op;
      den_nxt  = den;
      rem_nxt  = '0;
      root_nxt = '0;
      if (ctl.op == wdu_pkg::OP_DIV) begin
        sh_nxt  = num;
        cnt_nxt = CW'(UN);
      end else begin
        sh_nxt  = UN'(num[wdu_pkg::SQRT_IN_W-1:0]) << (UN - wdu_pkg::SQRT_IN_W);
        cnt_nxt = CW'(wdu_pkg::SQRT_STEPS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      op_r   <= wdu_pkg::OP_DIV;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
    root_r <= root_nxt;
    den_r  <= den_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = busy_r && last;
  assign quo      = sh_r;
  assign root     = root_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r) else $error("unit started while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |=> !busy_r) else $error("unit still busy after done");
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("unit busy with empty step count");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/weighted_depth_upsampler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_depth_upsampler
// Inverse distance weighted upsampling of lidar points onto pixel cells,
// and byte scaling of stored estimates against the frame maxima.
// ----------------------------------------------------------------------------
// Sharing: point words, cell closes and scale words all use the one divide/sqrt unit,
//   of width UN = 31+2*COORD_FRAC_BITS+2*SUBPIXEL_BITS, at least 64 (79 by default).
// Throughput: one word at a time; in_tready is high only while idle, and a
//   finished result waits in the output register without blocking input.
// Reset: synchronous active-low rst_n clears sums, maxima, control; ranges 1.0.
module weighted_depth_upsampler #(
  parameter int IMAGE_WIDTH     = 2048,
  parameter int IMAGE_HEIGHT    = 2048,
  parameter int SUBPIXEL_BITS   = 8,
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  // in_tdata: pixel_column[10:0], pixel_row[21:11], point_col_pos[40:22],
  //   point_row_pos[59:41], coord_x[91:60], coord_y[123:92], coord_z[155:124]
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [159:0] in_tdata,
  input  wire          in_tlast,   // last_point
  input  wire  [2:0]   in_tuser,   // mode, frame_start, empty_cell
  // out_tdata: est_x[31:0], est_y[63:32], est_z[95:64], byte_x[103:96],
  //   byte_y[111:104], byte_z[119:112]
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [119:0] out_tdata,
  input  wire          cfg_wr_en,
  input  wire  [1:0]   cfg_addr,
  input  wire  [30:0]  cfg_wdata
);

  localparam int SH   = 2 * COORD_FRAC_BITS + 2 * SUBPIXEL_BITS;
  localparam int NW   = 31 + SH;
  localparam int DW   = (((11 + SUBPIXEL_BITS) > 19) ? (11 + SUBPIXEL_BITS) : 19) + 1;
  localparam int GW   = 2 * DW - 1;
  localparam int DENW = GW + 31;
  localparam int UN   = (NW > 64) ? NW : 64;
  localparam int UD   = (DENW > 64) ? DENW : 64;

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_SQU    = 19'h00002,
    S_SQV    = 19'h00004,
    S_AXIS   = 19'h00008,
    S_DENHI  = 19'h00010,
    S_DSTART = 19'h00020,
    S_DWAIT  = 19'h00040,
    S_SSTART = 19'h00080,
    S_SWAIT  = 19'h00100,
    S_SGET   = 19'h00200,
    S_WMUL   = 19'h00400,
    S_ACC    = 19'h00800,
    S_CSTART = 19'h01000,
    S_CWAIT  = 19'h02000,
    S_CFIN   = 19'h04000,
    S_BSTART = 19'h08000,
    S_BWAIT  = 19'h10000,
    S_BFIN   = 19'h20000,
    S_OUT    = 19'h40000
  } state_t;

  state_t              state_r;
  logic [1:0]          ax_r;
  logic                zflag_r;

  // Latched input word
  logic                last_r;
  logic [10:0]         col_r, row_r;
  logic [18:0]         pcol_r, prow_r;
  logic signed [31:0]  coord_r [3];

  // Configuration and running state
  logic [30:0]         range_r [3];
  logic [63:0]         ws_r [3];
  logic [63:0]         wcs_r [3];
  logic [30:0]         max_r [3];
  logic [31:0]         est_r [3];
  logic [7:0]          byte_r [3];

  // Work registers
  logic [GW-1:0]       gs_r;
  logic [62:0]         prod_r;
  logic [DENW-1:0]     den_r;
  logic [31:0]         w_r;
  logic [62:0]         wc_r;

  logic                out_valid_r;
  logic [119:0]        out_data_r;

  // Shared unit
  wdu_pkg::unit_ctl_t  unit_ctl;
  wdu_pkg::unit_sts_t  unit_sts;
  logic [UN-1:0]       unit_num, unit_quo;
  logic [UD-1:0]       unit_den;
  logic [31:0]         unit_root;

  wdu_serial_unit #(.UN(UN), .UD(UD)) u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (unit_ctl),
    .num  (unit_num),
    .den  (unit_den),
    .sts  (unit_sts),
    .quo  (unit_quo),
    .root (unit_root)
  );

  // Input unpacking
  logic        in_acc;
  logic        in_mode, in_fstart, in_empty;
  logic [10:0] in_col, in_row;
  logic        in_outside;

  assign in_tready = state_r == S_IDLE;
  assign in_acc    = in_tvalid && in_tready;
  assign in_mode   = in_tuser[0];
  assign in_fstart = in_tuser[1];
  assign in_empty  = in_tuser[2];
  assign in_col    = in_tdata[10:0];
  assign in_row    = in_tdata[21:11];
  assign in_outside = ({2'b00, in_col} >= 13'(IMAGE_WIDTH)) ||
                      ({2'b00, in_row} >= 13'(IMAGE_HEIGHT));

  // Distance and per-axis operands
  logic signed [DW-1:0]   du, dv, dsel;
  logic signed [2*DW-1:0] dsq;
  logic [GW-1:0]          sq;
  logic signed [31:0]     c;
  logic [30:0]            c31, rng;
  logic                   cpos;
  logic [62:0]            plo;
  logic [GW-2:0]          phi;
  logic [39:0]            bnum;
  logic [UN-1:0]          q;
  logic [30:0]            est31;
  logic [64:0]            ws_add, wcs_add;
  logic                   out_load;

  always_comb begin
    du   = $signed(DW'(col_r) << SUBPIXEL_BITS) - $signed(DW'(pcol_r));
    dv   = $signed(DW'(row_r) << SUBPIXEL_BITS) - $signed(DW'(prow_r));
    dsel = (state_r == S_SQU) ? du : dv;
    dsq  = dsel * dsel;
    sq   = GW'($unsigned(dsq));
    c    = coord_r[ax_r];
    c31  = c[30:0];
    cpos = !c[31] && (c31 != '0);
    rng  = range_r[ax_r];
    plo  = gs_r[31:0] * c31;
    phi  = gs_r[GW-1:32] * c31;
    bnum = c31 * wdu_pkg::BYTE_SCALE;
    q    = zflag_r ? '0 : unit_quo;
    est31 = ((q >> 31) != '0) ? wdu_pkg::EST_MAX : q[30:0];
    ws_add  = {1'b0, ws_r[ax_r]} + 65'(w_r);
    wcs_add = {1'b0, wcs_r[ax_r]} + 65'(wc_r);
    out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);
  end

  // Shared unit requests
  always_comb begin
    unit_ctl.start = 1'b0;
    unit_ctl.op    = wdu_pkg::OP_DIV;
    unit_num       = '0;
    unit_den       = '0;
    unique case (state_r)
      S_DSTART: begin
        unit_ctl.start = 1'b1;
        unit_num       = UN'(rng) << SH;
        unit_den       = UD'(den_r);
      end
      S_SSTART: begin
        unit_ctl.start = (unit_quo >> 64) == '0;
        unit_ctl.op    = wdu_pkg::OP_SQRT;
        unit_num       = unit_quo;
      end
      S_CSTART: begin
        unit_ctl.start = ws_r[ax_r] != '0;
        unit_num       = UN'(wcs_r[ax_r]);
        unit_den       = UD'(ws_r[ax_r]);
      end
      S_BSTART: begin
        unit_ctl.start = cpos && (max_r[ax_r] != '0);
        unit_num       = UN'(bnum);
        unit_den       = UD'(max_r[ax_r]);
      end
      default: begin
      end
    endcase
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= '0;
      zflag_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        range_r[i] <= wdu_pkg::RANGE_RESET;
        ws_r[i]    <= '0;
        wcs_r[i]   <= '0;
        max_r[i]   <= '0;
      end
    end else begin
      // Configuration writes
      if (cfg_wr_en) begin
        priority case (cfg_addr)
          wdu_pkg::CFG_RANGE_X: range_r[0] <= cfg_wdata;
          wdu_pkg::CFG_RANGE_Y: range_r[1] <= cfg_wdata;
          wdu_pkg::CFG_RANGE_Z: range_r[2] <= cfg_wdata;
          default: begin
          end
        endcase
      end

      // Output register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            ax_r <= '0;
            if (in_fstart) begin
              for (int i = 0; i < 3; i++) max_r[i] <= '0;
            end
            if (in_mode) begin
              for (int i = 0; i < 3; i++) est_r[i] <= '0;
              state_r <= S_BSTART;
            end else if (in_outside) begin
              state_r <= S_IDLE;
            end else if (in_empty) begin
              for (int i = 0; i < 3; i++) begin
                ws_r[i]   <= '0;
                wcs_r[i]  <= '0;
                byte_r[i] <= '0;
              end
              state_r <= S_CSTART;
            end else begin
              for (int i = 0; i < 3; i++) byte_r[i] <= '0;
              state_r <= S_SQU;
            end
          end
        end
        S_SQU: begin
          gs_r    <= sq;
          state_r <= S_SQV;
        end
        S_SQV: begin
          gs_r    <= gs_r + sq;
          state_r <= S_AXIS;
        end
        S_AXIS: begin
          if (!cpos || rng == '0) begin
            if (ax_r == 2'd2) begin
              ax_r    <= '0;
              state_r <= last_r ? S_CSTART : S_IDLE;
            end else begin
              ax_r    <= ax_r + 2'd1;
              state_r <= S_AXIS;
            end
          end else if (gs_r == '0) begin
            w_r     <= wdu_pkg::WEIGHT_MAX;
            state_r <= S_WMUL;
          end else begin
            prod_r  <= plo;
            state_r <= S_DENHI;
          end
        end
        S_DENHI: begin
          den_r   <= DENW'(prod_r) + (DENW'(phi) << 32);
          state_r <= S_DSTART;
        end
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (unit_sts.done) state_r <= S_SSTART;
        end
        S_SSTART: begin
          if ((unit_quo >> 64) != '0) begin
            w_r     <= wdu_pkg::WEIGHT_MAX;
            state_r <= S_WMUL;
          end else begin
            state_r <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          if (unit_sts.done) state_r <= S_SGET;
        end
        S_SGET: begin
          w_r     <= unit_root;
          state_r <= S_WMUL;
        end
        S_WMUL: begin
          wc_r    <= w_r * c31;
          state_r <= S_ACC;
        end
        S_ACC: begin
          // saturating sums
          ws_r[ax_r]  <= ws_add[64] ? '1 : ws_add[63:0];
          wcs_r[ax_r] <= wcs_add[64] ? '1 : wcs_add[63:0];
          if (ax_r == 2'd2) begin
            ax_r    <= '0;
            state_r <= last_r ? S_CSTART : S_IDLE;
          end else begin
            ax_r    <= ax_r + 2'd1;
            state_r <= S_AXIS;
          end
        end
        S_CSTART: begin
          zflag_r <= ws_r[ax_r] == '0;
          state_r <= (ws_r[ax_r] == '0) ? S_CFIN : S_CWAIT;
        end
        S_CWAIT: begin
          if (unit_sts.done) state_r <= S_CFIN;
        end
        S_CFIN: begin
          est_r[ax_r] <= {1'b0, est31};
          ws_r[ax_r]  <= '0;
          wcs_r[ax_r] <= '0;
          if (max_r[ax_r] < est31) max_r[ax_r] <= est31;
          if (ax_r == 2'd2) begin
            state_r <= S_OUT;
          end else begin
            ax_r    <= ax_r + 2'd1;
            state_r <= S_CSTART;
          end
        end
        S_BSTART: begin
          zflag_r <= !unit_ctl.start;
          state_r <= unit_ctl.start ? S_BWAIT : S_BFIN;
        end
        S_BWAIT: begin
          if (unit_sts.done) state_r <= S_BFIN;
        end
        S_BFIN: begin
          byte_r[ax_r] <= ((q >> 8) != '0) ? wdu_pkg::BYTE_MAX : q[7:0];
          if (ax_r == 2'd2) begin
            state_r <= S_OUT;
          end else begin
            ax_r    <= ax_r + 2'd1;
            state_r <= S_BSTART;
          end
        end
        S_OUT: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload latches
  always_ff @(posedge clk) begin
    if (in_acc) begin
      last_r     <= in_tlast;
      col_r      <= in_col;
      row_r      <= in_row;
      pcol_r     <= in_tdata[40:22];
      prow_r     <= in_tdata[59:41];
      coord_r[0] <= in_tdata[91:60];
      coord_r[1] <= in_tdata[123:92];
      coord_r[2] <= in_tdata[155:124];
    end
    if (out_load) begin
      out_data_r <= {byte_r[2], byte_r[1], byte_r[0], est_r[2], est_r[1], est_r[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !unit_sts.busy) else $error("input ready while unit busy");
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r) else $error("result load lost");
  a_start_state: assert property (@(posedge clk) disable iff (!rst_n)
    unit_ctl.start |-> (state_r == S_DSTART || state_r == S_SSTART ||
                        state_r == S_CSTART || state_r == S_BSTART))
    else $error("unit started outside a start state");
`endif

endmodule
`default_nettype wire

// ----- dv/weighted_depth_upsampler_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_depth_upsampler_test
// Drives point, empty-cell and scale words through the stream ports, predicts
// each cell estimate and byte scale in the bench and compares every result
// word field by field. Range registers are swept between phases.
// ----------------------------------------------------------------------------
module weighted_depth_upsampler_test;

  localparam int LATENCY = 800;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic        mode;
    logic        frame_start;
    logic        empty_cell;
    logic        last_point;
    logic [10:0] pix_col;
    logic [10:0] pix_row;
    logic [18:0] pt_col;
    logic [18:0] pt_row;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
  } pixel_word_t;

  typedef struct packed {
    logic [31:0] est_x, est_y, est_z;
    logic [7:0]  byte_x, byte_y, byte_z;
  } cell_result_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [159:0]  in_tdata = '0;
  logic          in_tlast = 1'b0;
  logic [2:0]    in_tuser = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [119:0]  out_tdata;
  logic          cfg_wr_en = 1'b0;
  logic [1:0]    cfg_addr = wdu_pkg::CFG_RANGE_X;
  logic [30:0]   cfg_wdata = '0;

  // bench copy of the block state
  logic [30:0]  rng [3];
  logic [63:0]  wsum [3];
  logic [63:0]  wcsum [3];
  logic [31:0]  fmax [3];

  cell_result_t expected_cells[$];
  int  failures = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 1'b0;
  longint cycle_count = 0;

  weighted_depth_upsampler uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** weighted_depth_upsampler: FAILED **");
      $finish;
    end
  end

  // floor(sqrt(range * 2^48 / (gs * coord))), saturating
  function automatic logic [31:0] point_weight(logic [63:0] gs, logic [31:0] coord,
                                               logic [30:0] range_q);
    logic [127:0] num, den, quo;
    logic [63:0]  root, trial;
    if ($signed(coord) <= 0 || range_q == 0) return 32'd0;
    if (gs == 0) return wdu_pkg::WEIGHT_MAX;
    num = {97'd0, range_q} << 48;
    den = gs * {96'd0, coord};
    quo = num / den;
    if (quo[127:64] != 0) return wdu_pkg::WEIGHT_MAX;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= quo[63:0]) root = trial;
    end
    return root[31:0];
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  function automatic logic [7:0] scale_byte(logic [31:0] est, logic [31:0] mx);
    logic [63:0] v;
    if ($signed(est) <= 0 || $signed(mx) <= 0) return 8'd0;
    v = (64'd255 * {32'd0, est}) / {32'd0, mx};
    return (v > 255) ? wdu_pkg::BYTE_MAX : v[7:0];
  endfunction

  // advance the state by one word; returns 1 when a result is due
  function automatic bit predict_cell(pixel_word_t w, output cell_result_t r);
    logic [31:0] crd [3];
    logic [31:0] wt;
    logic [63:0] q, gs;
    logic signed [31:0] du, dv;
    crd[0] = w.cx; crd[1] = w.cy; crd[2] = w.cz;
    r = '0;
    if (w.frame_start) fmax = '{default: '0};
    if (w.mode) begin
      r.byte_x = scale_byte(w.cx, fmax[0]);
      r.byte_y = scale_byte(w.cy, fmax[1]);
      r.byte_z = scale_byte(w.cz, fmax[2]);
      return 1'b1;
    end
    if (!w.empty_cell) begin
      du = $signed({13'd0, w.pix_col, 8'd0}) - $signed({13'd0, w.pt_col});
      dv = $signed({13'd0, w.pix_row, 8'd0}) - $signed({13'd0, w.pt_row});
      gs = 64'(longint'(du) * longint'(du)) + 64'(longint'(dv) * longint'(dv));
      for (int a = 0; a < 3; a++) begin
        if ($signed(crd[a]) > 0 && rng[a] != 0) begin
          wt = point_weight(gs, crd[a], rng[a]);
          if (wt != 0) begin
            wsum[a]  = sat_sum(wsum[a], {32'd0, wt});
            wcsum[a] = sat_sum(wcsum[a], {32'd0, wt} * {32'd0, crd[a]});
          end
        end
      end
      if (!w.last_point) return 1'b0;
    end else begin
      wsum = '{default: '0};
      wcsum = '{default: '0};
    end
    for (int a = 0; a < 3; a++) begin
      q = 0;
      if (wsum[a] != 0) begin
        q = wcsum[a] / wsum[a];
        if (q > {33'd0, wdu_pkg::EST_MAX}) q = {33'd0, wdu_pkg::EST_MAX};
      end
      wsum[a] = 0; wcsum[a] = 0;
      if ($signed(fmax[a]) < $signed(q[31:0])) fmax[a] = q[31:0];
      crd[a] = q[31:0];
    end
    r.est_x = crd[0]; r.est_y = crd[1]; r.est_z = crd[2];
    return 1'b1;
  endfunction

  // offer one word; a typed expectation replaces the predicted one
  task automatic send_word(pixel_word_t w, bit has_want, cell_result_t want);
    cell_result_t r;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, w.cz, w.cy, w.cx, w.pt_row, w.pt_col, w.pix_row, w.pix_col};
    in_tlast  <= w.last_point;
    in_tuser  <= {w.empty_cell, w.frame_start, w.mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (predict_cell(w, r)) expected_cells.push_back(has_want ? want : r);
  endtask

  task automatic write_range(logic [1:0] idx, logic [30:0] val);
    cfg_wr_en <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    rng[idx] = val;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h8000_0000 | $urandom();
      2: return 32'd0;
      default: return $urandom_range(32'h0040_0000, 1);
    endcase
  endfunction

  function automatic pixel_word_t rand_point(bit last);
    pixel_word_t w;
    w.mode = 1'b0;
    w.frame_start = ($urandom_range(40) == 0);
    w.empty_cell = 1'b0;
    w.last_point = last;
    w.pix_col = $urandom_range(100) == 0 ? 11'h7FF : 11'($urandom());
    w.pix_row = 11'($urandom());
    w.pt_col = $urandom_range(3) == 0 ? 19'({w.pix_col, 8'd0} + $urandom_range(511))
                                      : 19'($urandom());
    w.pt_row = $urandom_range(3) == 0 ? 19'({w.pix_row, 8'd0} + $urandom_range(511))
                                      : 19'($urandom());
    w.cx = rand_coord(); w.cy = rand_coord(); w.cz = rand_coord();
    return w;
  endfunction

  // result checker
  always @(posedge clk) begin
    cell_result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.est_x = out_tdata[31:0];   got.est_y = out_tdata[63:32];
      got.est_z = out_tdata[95:64];  got.byte_x = out_tdata[103:96];
      got.byte_y = out_tdata[111:104]; got.byte_z = out_tdata[119:112];
      if (expected_cells.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        failures++;
      end else begin
        want = expected_cells.pop_front();
        if (got.est_x != want.est_x) begin
          $error("est_x: expected %h, got %h", want.est_x, got.est_x); failures++;
        end
        if (got.est_y != want.est_y) begin
          $error("est_y: expected %h, got %h", want.est_y, got.est_y); failures++;
        end
        if (got.est_z != want.est_z) begin
          $error("est_z: expected %h, got %h", want.est_z, got.est_z); failures++;
        end
        if (got.byte_x != want.byte_x) begin
          $error("byte_x: expected %h, got %h", want.byte_x, got.byte_x); failures++;
        end
        if (got.byte_y != want.byte_y) begin
          $error("byte_y: expected %h, got %h", want.byte_y, got.byte_y); failures++;
        end
        if (got.byte_z != want.byte_z) begin
          $error("byte_z: expected %h, got %h", want.byte_z, got.byte_z); failures++;
        end
      end
    end
  end

  // receiver ready, with random stalls and a long hold-off
  always @(posedge clk) begin
    if (recv_hold) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    recv_hold = 1'b1;
    wait (cycle_count == 3000);
    repeat (5000) @(posedge clk);
    recv_hold = 1'b0;
  end

  // directed words; has_want marks rows whose result is typed in
  typedef struct {
    pixel_word_t  w;
    bit           has_want;
    cell_result_t want;
  } directed_row_t;

  initial begin
    directed_row_t rows[$];
    pixel_word_t   w;
    cell_result_t  none;
    none = '0;
    rng = '{wdu_pkg::RANGE_RESET, wdu_pkg::RANGE_RESET, wdu_pkg::RANGE_RESET};
    wsum = '{default: '0}; wcsum = '{default: '0}; fmax = '{default: '0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // scale right after reset: zero maximum gives byte 0
    w = '{mode: 1, frame_start: 0, empty_cell: 0, last_point: 0, pix_col: 0, pix_row: 0,
          pt_col: 0, pt_row: 0, cx: 32'h7FFF_FFFF, cy: 32'h0001_0000, cz: 32'h8000_0000};
    rows.push_back('{w, 1, none});
    // empty cell: zero estimate
    w = '{mode: 0, frame_start: 1, empty_cell: 1, last_point: 1, pix_col: 11'h7FF,
          pix_row: 11'h7FF, pt_col: 19'h7FFFF, pt_row: 19'h7FFFF, cx: '1, cy: '1, cz: '1};
    rows.push_back('{w, 1, none});
    // all non-positive coords: no weight, estimate 0
    w = '{mode: 0, frame_start: 0, empty_cell: 0, last_point: 1, pix_col: 5, pix_row: 7,
          pt_col: 19'h500, pt_row: 19'h700, cx: 32'd0, cy: 32'hFFFF_FFFF, cz: 32'h8000_0000};
    rows.push_back('{w, 1, none});
    // single point at zero distance: estimate equals coordinate
    w = '{mode: 0, frame_start: 0, empty_cell: 0, last_point: 1, pix_col: 3, pix_row: 4,
          pt_col: 19'h300, pt_row: 19'h400, cx: 32'h0002_0000, cy: 32'h7FFF_FFFF, cz: 32'd1};
    rows.push_back('{w, 1, '{32'h0002_0000, 32'h7FFF_FFFF, 32'd1, 8'd0, 8'd0, 8'd0}});
    // scale against those maxima
    w = '{mode: 1, frame_start: 0, empty_cell: 0, last_point: 0, pix_col: 0, pix_row: 0,
          pt_col: 0, pt_row: 0, cx: 32'h0002_0000, cy: 32'h7FFF_FFFF, cz: 32'hFFFF_FFFF};
    rows.push_back('{w, 1, '{32'd0, 32'd0, 32'd0, 8'd255, 8'd255, 8'd0}});
    // out-of-range coordinate above maximum clamps to 255
    w.cx = 32'h0004_0000; w.cy = 32'h3FFF_FFFF; w.cz = 32'd2;
    rows.push_back('{w, 0, none});
    // multi-point cell, far points, max subpixel positions
    for (int i = 0; i < 4; i++) begin
      w = '{mode: 0, frame_start: 0, empty_cell: 0, last_point: (i == 3),
            pix_col: 11'd2047, pix_row: 11'd0, pt_col: (i == 0) ? 19'h7FFFF : 19'd0,
            pt_row: 19'h7FFFF >> i, cx: 32'h0001_0000 << i, cy: 32'h7FFF_FFFF,
            cz: 32'd1 << (i * 8)};
      rows.push_back('{w, 0, none});
    end
    // frame start in scale mode clears maxima: byte 0
    w = '{mode: 1, frame_start: 1, empty_cell: 1, last_point: 1, pix_col: '1, pix_row: '1,
          pt_col: '1, pt_row: '1, cx: 32'h0001_0000, cy: 32'h0001_0000, cz: 32'h0001_0000};
    rows.push_back('{w, 1, none});

    foreach (rows[i]) begin
      send_word(rows[i].w, rows[i].has_want, rows[i].want);
    end
    drain();

    // phases of range settings and idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_range(wdu_pkg::CFG_RANGE_X, 31'd1);
          write_range(wdu_pkg::CFG_RANGE_Y, 31'h7FFF_FFFF);
          write_range(wdu_pkg::CFG_RANGE_Z, 31'd0);
          send_idle_pct = 35; recv_idle_pct = 88;
        end
        1: begin
          write_range(wdu_pkg::CFG_RANGE_X, 31'h7FFF_FFFF);
          write_range(wdu_pkg::CFG_RANGE_Y, 31'($urandom()));
          write_range(wdu_pkg::CFG_RANGE_Z, 31'd1);
          send_idle_pct = 88; recv_idle_pct = 35;
        end
        2: begin
          write_range(wdu_pkg::CFG_RANGE_X, 31'($urandom_range(32'h0010_0000, 1)));
          write_range(wdu_pkg::CFG_RANGE_Y, 31'($urandom_range(32'h0010_0000, 1)));
          write_range(wdu_pkg::CFG_RANGE_Z, wdu_pkg::RANGE_RESET);
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        default: begin
          write_range(wdu_pkg::CFG_RANGE_X, wdu_pkg::RANGE_RESET);
          write_range(wdu_pkg::CFG_RANGE_Y, 31'd1);
          write_range(wdu_pkg::CFG_RANGE_Z, 31'($urandom()));
        end
      endcase
      for (int n = 0; n < 140; ) begin
        case ($urandom_range(9))
          0: begin
            w = rand_point(1'b1); w.pix_col = 11'd2047; w.empty_cell = 1'b1;
            send_word(w, 1'b0, none); n++;
          end
          1, 2: begin
            w = rand_point(1'b0); w.mode = 1'b1;
            w.empty_cell = 1'($urandom()); w.last_point = 1'($urandom());
            send_word(w, 1'b0, none); n++;
          end
          default: begin
            int pts;
            pts = $urandom_range(4, 1);
            for (int k = 0; k < pts; k++) begin
              send_word(rand_point(k == pts - 1 || $urandom_range(9) == 0), 1'b0, none);
              n++;
            end
          end
        endcase
      end
      drain();
    end

    if (failures == 0) begin
      $display("** weighted_depth_upsampler: PASSED **");
    end else begin
      $display("** weighted_depth_upsampler: FAILED **");
    end
    $finish;
  end

endmodule
